FILE: sv/shbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shbc_pkg: shared types and constants
// Field widths, register codes, sequencer states and the fixed-point
// constants of the skin and hair classifier.
// ----------------------------------------------------------------------------
package shbc_pkg;

	localparam int CH_W       = 8;
	localparam int FW_W       = 13;
	localparam int GW_W       = 4;
	localparam int POS_W      = 12;
	localparam int CNT_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH = 1'b0,
		CFG_GROUP_WIDTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_SUM,
		ST_CMP,
		ST_WRITE
	} seq_state_t;

	typedef logic signed [51:0] wide_t;

	localparam logic [FW_W-1:0] FW_RESET = 13'd640;
	localparam logic [FW_W-1:0] FW_MAX   = 13'd4096;
	localparam logic [GW_W-1:0] GW_RESET = 4'd7;

	// Quadratic chromaticity bounds, Q16 coefficients, constant term in Q.48
	localparam logic [16:0] F1_A = 17'd90178;
	localparam logic [16:0] F1_B = 17'd70405;
	localparam wide_t       F1_C = wide_t'({20'd13107, 32'd0});
	localparam logic [16:0] F2_A = 17'd50856;
	localparam logic [16:0] F2_B = 17'd36707;
	localparam wide_t       F2_C = wide_t'({20'd11796, 32'd0});

	localparam logic signed [17:0] CHROMA_CENTRE = 18'sd21627;
	localparam logic [31:0]        DIST_MIN      = 32'd4294967;

	// 4*cos^2 of the hue limits in Q16
	localparam logic [17:0] COS20_Q16 = 18'd231479;
	localparam logic [17:0] COS40_Q16 = 18'd153832;

	localparam logic [9:0]        DARK_SUM    = 10'd240;
	localparam logic signed [8:0] BLUE_MARGIN = 9'sd15;

endpackage
`default_nettype wire

FILE: sv/shbc_pix_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shbc_pix_if: pixel channel
// One RGB pixel per beat with a start-of-frame mark.
// ----------------------------------------------------------------------------
interface shbc_pix_if
	import shbc_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic            start_of_frame;

	modport source (output valid, output red, output green, output blue,
		output start_of_frame, input ready);
	modport sink (input valid, input red, input green, input blue,
		input start_of_frame, output ready);
endinterface
`default_nettype wire

FILE: sv/shbc_blk_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shbc_blk_if: block result channel
// One finished block per beat: skin and hair flags and the block position.
// ----------------------------------------------------------------------------
interface shbc_blk_if
	import shbc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             skin_block;
	logic             hair_block;
	logic [POS_W-1:0] block_column;
	logic [POS_W-1:0] block_row;

	modport source (output valid, output skin_block, output hair_block,
		output block_column, output block_row, input ready);
	modport sink (input valid, input skin_block, input hair_block,
		input block_column, input block_row, output ready);
endinterface
`default_nettype wire

FILE: sv/skin_hair_block_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skin_hair_block_classifier: block-wise skin and hair voting
// Classifies raster pixels as skin and hair and counts the votes per square
// block in a per-column count memory; reports each full block at its last
// pixel.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  --------+-----+---------------------------------------------------------
//  pix     | in  | red, green, blue, start_of_frame
//  blk     | out | skin_block, hair_block, block_column, block_row
//  cfg     | in  | cfg_we, cfg_addr (0 frame_width, 1 group_width), cfg_wdata
//
//  One pixel at a time, no new pixel until write-back: accept, four arithmetic
//  steps (squares, constant products, wide sums, compares), then the count
//  write-back. The count memory is read at accept and written in the last step.
//  Reset clears control and position state only; count entries hold garbage
//  until a block's first pixel overwrites them, so there is no clearing pass.
//  A block-closing write-back holds while a finished block still waits on blk.
// ----------------------------------------------------------------------------
module skin_hair_block_classifier
	import shbc_pkg::*;
#(
	parameter int MAX_BLOCK_COLUMNS = 1024
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_addr,
	input  wire [CFG_DATA_W-1:0] cfg_wdata,
	shbc_pix_if.sink             pix,
	shbc_blk_if.source           blk
);

	localparam int IDX_W = $clog2(MAX_BLOCK_COLUMNS);
	localparam logic [FW_W-1:0] MAX_COLS = FW_W'(MAX_BLOCK_COLUMNS);

	// ---------------- configuration ----------------
	logic [FW_W-1:0] frame_width_q;
	logic [GW_W-1:0] group_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FW_RESET;
			group_width_q <= GW_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				CFG_FRAME_WIDTH: frame_width_q <= cfg_wdata[FW_W-1:0];
				CFG_GROUP_WIDTH: group_width_q <= cfg_wdata[GW_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	seq_state_t state_q, state_d;
	logic       in_ready;
	logic       write_go;
	logic       load;
	logic       emit;
	logic       out_valid_q;

	assign load      = in_ready && pix.valid;
	assign pix.ready = in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (pix.valid) state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_SUM;
			ST_SUM:   state_d = ST_CMP;
			ST_CMP:   state_d = ST_WRITE;
			ST_WRITE: if (write_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		write_go = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_WRITE: write_go = !(emit && out_valid_q && !blk.ready);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// ---------------- raster position ----------------
	logic [POS_W-1:0] pc_q, cbc_q, cbr_q;
	logic [GW_W-1:0]  cib_q, rib_q;
	logic [POS_W-1:0] pc_c, cbc_c, cbr_c;
	logic [GW_W-1:0]  cib_c, rib_c;
	logic [FW_W-1:0]  fw_eff;
	logic [GW_W-1:0]  gw_eff;
	logic [16:0]      blk_end;
	logic             in_range;
	logic             first_c, last_c;
	logic [CNT_W-1:0] half_c;
	logic [7:0]       gw_sq;
	logic             row_end;
	logic [GW_W:0]    cib_inc, rib_inc;

	always_comb begin
		fw_eff = frame_width_q;
		if (frame_width_q == '0)        fw_eff = FW_W'(1);
		else if (frame_width_q > FW_MAX) fw_eff = FW_MAX;
		gw_eff = (group_width_q == '0) ? GW_W'(1) : group_width_q;

		// start of frame returns the position to the origin before use
		pc_c  = pix.start_of_frame ? '0 : pc_q;
		cbc_c = pix.start_of_frame ? '0 : cbc_q;
		cbr_c = pix.start_of_frame ? '0 : cbr_q;
		cib_c = pix.start_of_frame ? '0 : cib_q;
		rib_c = pix.start_of_frame ? '0 : rib_q;

		blk_end  = (17'(cbc_c) + 17'd1) * 17'(gw_eff);
		in_range = (blk_end <= 17'(fw_eff)) && ({1'b0, cbc_c} < MAX_COLS);
		first_c  = (rib_c == '0) && (cib_c == '0);
		last_c   = (rib_c == gw_eff - GW_W'(1)) && (cib_c == gw_eff - GW_W'(1));
		gw_sq    = 8'(gw_eff) * 8'(gw_eff);
		half_c   = gw_sq >> 1;

		row_end = (13'(pc_c) + 13'd1) >= fw_eff;
		cib_inc = {1'b0, cib_c} + 5'd1;
		rib_inc = {1'b0, rib_c} + 5'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			cbc_q <= '0;
			cbr_q <= '0;
			cib_q <= '0;
			rib_q <= '0;
		end else if (load) begin
			if (row_end) begin
				pc_q  <= '0;
				cib_q <= '0;
				cbc_q <= '0;
				if (rib_inc >= {1'b0, gw_eff}) begin
					rib_q <= '0;
					cbr_q <= cbr_c + POS_W'(1);
				end else begin
					rib_q <= rib_inc[GW_W-1:0];
					cbr_q <= cbr_c;
				end
			end else begin
				pc_q  <= pc_c + POS_W'(1);
				rib_q <= rib_c;
				cbr_q <= cbr_c;
				if (cib_inc >= {1'b0, gw_eff}) begin
					cib_q <= '0;
					cbc_q <= cbc_c + POS_W'(1);
				end else begin
					cib_q <= cib_inc[GW_W-1:0];
					cbc_q <= cbc_c;
				end
			end
		end
	end

	// ---------------- stage 1: captured pixel and block context ----------------
	logic [CH_W-1:0]  red_s1, green_s1, blue_s1;
	logic [16:0]      r_s1, g_s1;
	logic             act_s1, first_s1, last_s1;
	logic [POS_W-1:0] col_s1, row_s1;
	logic [CNT_W-1:0] half_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else if (load) begin
			act_s1 <= in_range;
		end
	end

	// R/255 in Q16 rounds to R*257 plus one for the upper half
	always_ff @(posedge clk) begin
		if (load) begin
			red_s1   <= pix.red;
			green_s1 <= pix.green;
			blue_s1  <= pix.blue;
			r_s1     <= {1'b0, pix.red, pix.red} + 17'(pix.red[CH_W-1]);
			g_s1     <= {1'b0, pix.green, pix.green} + 17'(pix.green[CH_W-1]);
			first_s1 <= first_c;
			last_s1  <= last_c;
			col_s1   <= cbc_c;
			row_s1   <= cbr_c;
			half_s1  <= half_c;
		end
	end

	// ---------------- count memory ----------------
	logic [2*CNT_W-1:0] cnt_mem [MAX_BLOCK_COLUMNS];
	logic [2*CNT_W-1:0] rd_q;
	logic [CNT_W-1:0]   skin_new, hair_new;

	always_ff @(posedge clk) begin
		if (load)
			rd_q <= cnt_mem[cbc_c[IDX_W-1:0]];
		if (write_go && act_s1)
			cnt_mem[col_s1[IDX_W-1:0]] <= {skin_new, hair_new};
	end

	// ---------------- stage 2: squares and hue terms ----------------
	logic signed [18:0] a_c, b_c, c_c;
	logic signed [18:0] d_c;
	logic signed [19:0] n_c;
	logic signed [19:0] n2_c;
	logic signed [17:0] dr_c, dg_c;
	logic signed [35:0] dr2_c, dg2_c;
	logic [9:0]         rgb_sum_c;
	logic signed [8:0]  bg_c, br_c;

	always_comb begin
		a_c       = 19'(signed'({1'b0, red_s1}))   - 19'(signed'({1'b0, green_s1}));
		b_c       = 19'(signed'({1'b0, red_s1}))   - 19'(signed'({1'b0, blue_s1}));
		c_c       = 19'(signed'({1'b0, green_s1})) - 19'(signed'({1'b0, blue_s1}));
		d_c       = a_c * a_c + b_c * c_c;
		n_c       = 20'(a_c) + 20'(b_c);
		n2_c      = n_c * n_c;
		dr_c      = signed'({1'b0, r_s1}) - CHROMA_CENTRE;
		dg_c      = signed'({1'b0, g_s1}) - CHROMA_CENTRE;
		dr2_c     = 36'(dr_c) * 36'(dr_c);
		dg2_c     = 36'(dg_c) * 36'(dg_c);
		rgb_sum_c = 10'(red_s1) + 10'(green_s1) + 10'(blue_s1);
		bg_c      = signed'({1'b0, blue_s1}) - signed'({1'b0, green_s1});
		br_c      = signed'({1'b0, blue_s1}) - signed'({1'b0, red_s1});
	end

	logic [33:0]        r2_s2, m1_s2, m2_s2;
	logic [16:0]        g_s2, d_s2;
	logic [17:0]        n2_s2;
	logic signed [9:0]  n_s2;
	logic [30:0]        dr2_s2, dg2_s2;
	logic               bleg_s2, dark_s2;

	always_ff @(posedge clk) begin
		r2_s2   <= 34'(r_s1) * 34'(r_s1);
		m1_s2   <= 34'(r_s1) * 34'(F1_B);
		m2_s2   <= 34'(r_s1) * 34'(F2_B);
		g_s2    <= g_s1;
		d_s2    <= d_c[16:0];
		n_s2    <= n_c[9:0];
		n2_s2   <= n2_c[17:0];
		dr2_s2  <= dr2_c[30:0];
		dg2_s2  <= dg2_c[30:0];
		bleg_s2 <= blue_s1 <= green_s1;
		dark_s2 <= (rgb_sum_c < DARK_SUM) && ((bg_c < BLUE_MARGIN) || (br_c < BLUE_MARGIN));
	end

	// ---------------- stage 3: constant products ----------------
	logic [33:0]       k1h_s3, k1l_s3, k2h_s3, k2l_s3, m1_s3, m2_s3;
	logic [16:0]       g_s3, d_s3;
	logic [17:0]       n2_s3;
	logic signed [9:0] n_s3;
	logic [34:0]       q20_s3, q40_s3;
	logic              wfar_s3, bleg_s3, dark_s3;

	// split r^2 so each product stays within a 17-bit operand
	always_ff @(posedge clk) begin
		k1h_s3  <= 34'(r2_s2[33:17]) * 34'(F1_A);
		k1l_s3  <= 34'(r2_s2[16:0])  * 34'(F1_A);
		k2h_s3  <= 34'(r2_s2[33:17]) * 34'(F2_A);
		k2l_s3  <= 34'(r2_s2[16:0])  * 34'(F2_A);
		m1_s3   <= m1_s2;
		m2_s3   <= m2_s2;
		g_s3    <= g_s2;
		d_s3    <= d_s2;
		n2_s3   <= n2_s2;
		n_s3    <= n_s2;
		q20_s3  <= 35'(d_s2) * 35'(COS20_Q16);
		q40_s3  <= 35'(d_s2) * 35'(COS40_Q16);
		wfar_s3 <= (32'(dr2_s2) + 32'(dg2_s2)) > DIST_MIN;
		bleg_s3 <= bleg_s2;
		dark_s3 <= dark_s2;
	end

	// ---------------- stage 4: bound sums and hue votes ----------------
	logic [34:0] n2_sh_c;
	logic        npos_c, ge20_c, ge40_c, dnz_c;

	always_comb begin
		n2_sh_c = 35'({n2_s3, 16'b0});
		npos_c  = n_s3 > 10'sd0;
		ge20_c  = n2_sh_c >= q20_s3;
		ge40_c  = n2_sh_c >= q40_s3;
		dnz_c   = d_s3 != '0;
	end

	wide_t f1_s4, f2_s4, g48_s4;
	logic  wfar_s4, skin_hue_s4, hair_s4;

	always_ff @(posedge clk) begin
		f1_s4   <= F1_C + wide_t'({m1_s3, 16'b0}) - wide_t'({k1h_s3, 17'b0})
			- wide_t'(k1l_s3);
		f2_s4   <= F2_C + wide_t'({m2_s3, 16'b0}) - wide_t'({k2h_s3, 17'b0})
			- wide_t'(k2l_s3);
		g48_s4  <= wide_t'({g_s3, 32'b0});
		wfar_s4 <= wfar_s3;
		// blue above green puts the hue past 180 degrees
		skin_hue_s4 <= dnz_c && (bleg_s3 ? (npos_c && ge20_c)
			: (!n_s3[9] || (n2_s3 < 18'(d_s3))));
		hair_s4 <= dark_s3 || (dnz_c && bleg_s3 && !(npos_c && ge20_c)
			&& npos_c && ge40_c);
	end

	// ---------------- stage 5: final votes ----------------
	logic skin_s5, hair_s5;

	always_ff @(posedge clk) begin
		skin_s5 <= (g48_s4 > f2_s4) && (g48_s4 < f1_s4) && wfar_s4 && skin_hue_s4;
		hair_s5 <= hair_s4;
	end

	// ---------------- write-back and result ----------------
	assign emit     = act_s1 && last_s1;
	// first pixel of a block overwrites the stale count
	assign skin_new = first_s1 ? CNT_W'(skin_s5) : rd_q[2*CNT_W-1:CNT_W] + CNT_W'(skin_s5);
	assign hair_new = first_s1 ? CNT_W'(hair_s5) : rd_q[CNT_W-1:0] + CNT_W'(hair_s5);

	logic             skin_q, hair_q;
	logic [POS_W-1:0] col_q, row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (write_go && emit) begin
			out_valid_q <= 1'b1;
		end else if (blk.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (write_go && emit) begin
			skin_q <= skin_new >= half_s1;
			hair_q <= hair_new >= half_s1;
			col_q  <= col_s1;
			row_q  <= row_s1;
		end
	end

	assign blk.valid        = out_valid_q;
	assign blk.skin_block   = skin_q;
	assign blk.hair_block   = hair_q;
	assign blk.block_column = col_q;
	assign blk.block_row    = row_q;

`ifndef NO_ASSERTIONS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready) |=> !pix.ready)
		else $error("pixel accepted while another is in flight");

	a_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready) |-> ##5 (state_q == ST_WRITE))
		else $error("write-back step not reached on schedule");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(write_go && emit))
		else $error("block result raised without a finished block");

	a_pending_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !blk.ready) |=> out_valid_q)
		else $error("pending block result dropped");
`endif

endmodule
`default_nettype wire
